[rtl/dda_line_rasterizer_core_assert.svh]
// Assertion macros shared by the DDA line rasterizer modules.
// Each macro expands to one labeled concurrent assertion, disabled in reset.
`ifndef DDA_LINE_RASTERIZER_CORE_ASSERT_SVH
`define DDA_LINE_RASTERIZER_CORE_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define DLR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define DLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dda_lr_pkg.sv]
// Shared types and defaults for the DDA line rasterizer.
// No dependencies; used by the controller, datapath and top level.
package dda_lr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DIVIDE = 2'd1,
        ST_FINISH = 2'd2
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // start word accepted
        logic div_step;  // one quotient bit per axis
        logic finish;    // apply signs to the quotients
        logic pixel;     // step word accepted
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;  // output register can take a word this cycle
        logic side_zero; // incoming line has zero length
    } status_t;

endpackage

[rtl/dda_lr_ctrl.sv]
// Controller for the DDA line rasterizer: input handshake and divide sequencing.
// Depends on dda_lr_pkg and dda_line_rasterizer_core_assert.svh.
`include "dda_line_rasterizer_core_assert.svh"

module dda_lr_ctrl #(
    parameter int FRAC_BITS = dda_lr_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_mode,
    input  dda_lr_pkg::status_t status,
    output dda_lr_pkg::cmd_t    cmd
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);

    dda_lr_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dda_lr_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        accept       = 1'b0;
        unique case (state_reg)
            dda_lr_pkg::ST_IDLE:
            begin
                in_ready  = status.out_free;
                accept    = in_valid && status.out_free;
                cmd.load  = accept && !in_mode;
                cmd.pixel = accept && in_mode;
                cnt_next  = '0;
                if (cmd.load && !status.side_zero)
                begin
                    state_next = dda_lr_pkg::ST_DIVIDE;
                end
            end
            dda_lr_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = dda_lr_pkg::ST_FINISH;
                end
            end
            dda_lr_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = dda_lr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dda_lr_pkg::ST_IDLE;
            end
        endcase
    end

    `DLR_ASSERT_NEXT(a_div_entry, clk, rst_n, cmd.load && !status.side_zero,
        state_reg == dda_lr_pkg::ST_DIVIDE, "nonzero line did not start divide")
    `DLR_ASSERT_NEXT(a_div_length, clk, rst_n,
        state_reg == dda_lr_pkg::ST_DIVIDE && cnt_reg == CNT_LAST,
        state_reg == dda_lr_pkg::ST_FINISH, "divide ran past its last bit")
    `DLR_ASSERT_SAME(a_pixel_room, clk, rst_n, cmd.pixel, status.out_free,
        "step word taken with output register full")

endmodule

[rtl/dda_lr_datapath.sv]
// Datapath for the DDA line rasterizer: endpoint setup, shift-subtract divider,
// accumulators, rounding and output register. Depends on dda_lr_pkg and the assert macros.
`include "dda_line_rasterizer_core_assert.svh"

module dda_lr_datapath #(
    parameter int COORD_BITS = dda_lr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dda_lr_pkg::FRAC_BITS_DEF,
    parameter int IN_DATA_W  = 80,
    parameter int OUT_DATA_W = 56
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dda_lr_pkg::cmd_t      cmd,
    output dda_lr_pkg::status_t   status,
    input  logic [IN_DATA_W-1:0]  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic                  out_last
);

    localparam int C      = COORD_BITS;
    localparam int ACC_W  = COORD_BITS + FRAC_BITS + 1;
    localparam int STEP_W = FRAC_BITS + 2;
    localparam int QUO_W  = FRAC_BITS + 1;
    localparam int CNT_W  = COORD_BITS + 1;
    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

    // input unpack
    logic [C-1:0]  x0, y0, x1, y1;
    logic [31:0]   color_in;
    logic [C:0]    dx, dy, ndx, ndy;
    logic [C-1:0]  adx, ady, side;

    assign x0       = in_data[0*C +: C];
    assign y0       = in_data[1*C +: C];
    assign x1       = in_data[2*C +: C];
    assign y1       = in_data[3*C +: C];
    assign color_in = in_data[4*C +: 32];

    assign dx   = {x1[C-1], x1} - {x0[C-1], x0};
    assign dy   = {y1[C-1], y1} - {y0[C-1], y0};
    assign ndx  = -dx;
    assign ndy  = -dy;
    assign adx  = dx[C] ? ndx[C-1:0] : dx[C-1:0];
    assign ady  = dy[C] ? ndy[C-1:0] : dy[C-1:0];
    assign side = (adx >= ady) ? adx : ady;

    // state
    logic [ACC_W-1:0]  accum_x_reg, accum_y_reg;
    logic [STEP_W-1:0] step_x_reg, step_y_reg;
    logic [CNT_W-1:0]  pixels_left_reg;
    logic [31:0]       color_reg;
    logic              line_active_reg;

    // divider: partial remainder already shifted, one quotient bit per step
    logic [C-1:0]      side_reg;
    logic [C:0]        wx_reg, wy_reg;
    logic [QUO_W-1:0]  qx_reg, qy_reg;
    logic              sx_neg_reg, sy_neg_reg;
    logic              gex, gey;
    logic [C:0]        rx, ry;

    assign gex = wx_reg >= {1'b0, side_reg};
    assign gey = wy_reg >= {1'b0, side_reg};
    assign rx  = gex ? (wx_reg - {1'b0, side_reg}) : wx_reg;
    assign ry  = gey ? (wy_reg - {1'b0, side_reg}) : wy_reg;

    // rounding: ties away from zero is (a + half - sign) floored
    logic [ACC_W-1:0] rnd_x, rnd_y;
    logic             emit;

    assign rnd_x = accum_x_reg + HALF - ACC_W'(accum_x_reg[ACC_W-1]);
    assign rnd_y = accum_y_reg + HALF - ACC_W'(accum_y_reg[ACC_W-1]);
    assign emit  = cmd.pixel && line_active_reg;

    // output register
    logic         out_valid_reg;
    logic [C-1:0] px_reg, py_reg;
    logic [31:0]  pcolor_reg;
    logic         plast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg <= 1'b0;
            pixels_left_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                line_active_reg <= 1'b1;
                pixels_left_reg <= {1'b0, side} + 1'b1;
            end
            else if (emit)
            begin
                pixels_left_reg <= pixels_left_reg - 1'b1;
                if (pixels_left_reg == CNT_W'(1))
                begin
                    line_active_reg <= 1'b0;
                end
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            accum_x_reg <= {x0[C-1], x0, {FRAC_BITS{1'b0}}};
            accum_y_reg <= {y0[C-1], y0, {FRAC_BITS{1'b0}}};
            step_x_reg  <= '0;
            step_y_reg  <= '0;
            color_reg   <= color_in;
            side_reg    <= side;
            wx_reg      <= {1'b0, adx};
            wy_reg      <= {1'b0, ady};
            qx_reg      <= '0;
            qy_reg      <= '0;
            sx_neg_reg  <= dx[C];
            sy_neg_reg  <= dy[C];
        end
        else if (cmd.div_step)
        begin
            wx_reg <= {rx[C-1:0], 1'b0};
            wy_reg <= {ry[C-1:0], 1'b0};
            qx_reg <= {qx_reg[QUO_W-2:0], gex};
            qy_reg <= {qy_reg[QUO_W-2:0], gey};
        end
        else if (cmd.finish)
        begin
            step_x_reg <= sx_neg_reg ? (STEP_W'(0) - {1'b0, qx_reg}) : {1'b0, qx_reg};
            step_y_reg <= sy_neg_reg ? (STEP_W'(0) - {1'b0, qy_reg}) : {1'b0, qy_reg};
        end
        else if (emit)
        begin
            accum_x_reg <= accum_x_reg + {{(ACC_W-STEP_W){step_x_reg[STEP_W-1]}}, step_x_reg};
            accum_y_reg <= accum_y_reg + {{(ACC_W-STEP_W){step_y_reg[STEP_W-1]}}, step_y_reg};
        end

        if (emit)
        begin
            px_reg     <= rnd_x[FRAC_BITS +: C];
            py_reg     <= rnd_y[FRAC_BITS +: C];
            pcolor_reg <= color_reg;
            plast_reg  <= (pixels_left_reg == CNT_W'(1));
        end
    end

    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.side_zero = (side == '0);

    assign out_valid = out_valid_reg;
    assign out_data  = OUT_DATA_W'({pcolor_reg, py_reg, px_reg});
    assign out_last  = plast_reg;

    `DLR_ASSERT_SAME(a_active_count, clk, rst_n, line_active_reg,
        pixels_left_reg != '0, "active line with no pixels left")
    `DLR_ASSERT_NEXT(a_last_ends_line, clk, rst_n, emit && pixels_left_reg == CNT_W'(1),
        !line_active_reg && out_valid_reg && plast_reg, "last pixel did not close the line")

endmodule

[rtl/dda_line_rasterizer_core.sv]
// DDA line rasterizer, top level.
// Usage:
//   s_axis carries command words. tuser = mode: 0 starts a line from the
//   endpoints and color in tdata and produces nothing; 1 asks for the next
//   pixel of the active line (ignored when no line is active).
//   m_axis carries pixel words; tlast marks the final pixel of a line.
// Handshake and sequencing:
//   A step word gives its pixel on m_axis in the cycle after acceptance; step
//   words can be taken every cycle while the receiver keeps up.
//   A start word of nonzero length occupies the shift-subtract divider
//   (ST_DIVIDE) and then a sign step (ST_FINISH); the input is held off
//   until both are done. A zero-length line needs no divide and the next
//   word may follow at once.
// Reset clears the controller, the output valid and the active-line flag.
// When m_axis stalls, the pending pixel holds in the output register and
// s_axis_tready drops until it is taken.
// Depends on dda_lr_pkg, dda_lr_ctrl and dda_lr_datapath.
module dda_line_rasterizer_core #(
    parameter int  COORD_BITS = dda_lr_pkg::COORD_BITS_DEF,
    parameter int  FRAC_BITS  = dda_lr_pkg::FRAC_BITS_DEF,
    localparam int IN_DATA_W  = ((4 * COORD_BITS + 32 + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((2 * COORD_BITS + 32 + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // start_x, start_y, end_x, end_y, line_color, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pixel_x, pixel_y, pixel_color, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    dda_lr_pkg::cmd_t    cmd;
    dda_lr_pkg::status_t status;

    dda_lr_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_mode  (s_axis_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    dda_lr_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .IN_DATA_W  (IN_DATA_W),
        .OUT_DATA_W (OUT_DATA_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
